FILE: sv/ppd_pkg.sv
// Shared types and constants for the period peak detector.
// Used by the detector top level and its port checker; no dependencies.
package ppd_pkg;

  // Datapath widths
  localparam int SAMPLE_BITS = 16;
  localparam int INDEX_BITS  = 32;
  localparam int OUT_BITS    = 32;
  localparam int COUNT_BITS  = 16;
  localparam int RATIO_BITS  = 8;
  localparam int DATA_BITS   = 32;
  localparam int ADDR_BITS   = 3;

  localparam int CMP_BITS = (INDEX_BITS > OUT_BITS) ? INDEX_BITS : OUT_BITS;
  localparam logic [OUT_BITS-1:0]   OUT_MAX   = '1;
  localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Register reset values (ratio is Q4.4, 7.0)
  localparam logic [RATIO_BITS-1:0]         RATIO_RESET    = 8'd112;
  localparam logic signed [SAMPLE_BITS-1:0] MIN_PEAK_RESET = '0;

  // Item function codes
  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_FLUSH  = 1'b1
  } func_t;

  // Register map, selected by paddr[2]
  typedef enum logic {
    REG_RATIO_Q4 = 1'b0,
    REG_MIN_PEAK = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    func_t                          func;
    logic signed [SAMPLE_BITS-1:0]  sample;
  } in_item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0]            peak_index;
    logic signed [SAMPLE_BITS-1:0]  peak_value;
    logic [OUT_BITS-1:0]            min_gap;
    logic                           gap_valid;
    logic [COUNT_BITS-1:0]          period_number;
    logic                           is_final;
  } out_item_t;

  // Clamp an index onto the 32-bit result field
  function automatic logic [OUT_BITS-1:0] sat_out(input logic [INDEX_BITS-1:0] v);
    logic [CMP_BITS-1:0] w;
    w = CMP_BITS'(v);
    if (w > CMP_BITS'(OUT_MAX)) begin
      return OUT_MAX;
    end
    return OUT_BITS'(w);
  endfunction

endpackage

FILE: sv/period_peak_detector_unit.sv
// Period peak detector: splits a sample stream into periods by min/max tracking.
// Depends on ppd_pkg for item types, register codes and widths.
//
// Channel   Direction  Handshake                 Payload
// in_       input      in_valid / in_ready       ppd_pkg::in_item_t
// out_      output     out_valid / out_ready     ppd_pkg::out_item_t
// APB cfg   input      psel/penable/pwrite       ratio_q4 @0x0, min_peak @0x4
//
// One item per cycle sustained unless a held result stalls the update stage; an
// accepted item yields its record (if any) through the input register, then one
// pass of compares and one 17x8 multiply into the result register.
// rst_n is synchronous and active low; it clears state and restores registers.
// A held result blocks the update stage only while out_ready is low; the
// input register still takes one more transaction during that stall.
module period_peak_detector_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ppd_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ppd_pkg::out_item_t                out_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ppd_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [ppd_pkg::DATA_BITS-1:0]     pwdata,
  output logic [ppd_pkg::DATA_BITS-1:0]     prdata,
  output logic                              pready
);

  localparam int MAG_BITS  = ppd_pkg::SAMPLE_BITS + 1;
  localparam int PROD_BITS = MAG_BITS + ppd_pkg::RATIO_BITS;
  localparam logic [1:0] PRIMED_FULL = 2'd2;

  // Magnitude of a signed sample, one bit wider
  function automatic logic [MAG_BITS-1:0] mag(input logic signed [ppd_pkg::SAMPLE_BITS-1:0] v);
    logic [MAG_BITS-1:0] e;
    e = MAG_BITS'(unsigned'({v[ppd_pkg::SAMPLE_BITS-1], v}));
    return v[ppd_pkg::SAMPLE_BITS-1] ? (~e + 1'b1) : e;
  endfunction

  // Configuration registers
  logic [ppd_pkg::RATIO_BITS-1:0]          ratio_r;
  logic signed [ppd_pkg::SAMPLE_BITS-1:0]  min_peak_r;

  // Pipeline registers
  logic                 in_vld_r;
  ppd_pkg::in_item_t    in_item_r;
  logic                 out_vld_r;
  ppd_pkg::out_item_t   out_item_r;

  // Detector state
  logic signed [ppd_pkg::SAMPLE_BITS-1:0] older_r, older_nxt;
  logic signed [ppd_pkg::SAMPLE_BITS-1:0] newer_r, newer_nxt;
  logic [1:0]                             primed_r, primed_nxt;
  logic [ppd_pkg::INDEX_BITS-1:0]         count_r, count_nxt;
  logic signed [ppd_pkg::SAMPLE_BITS-1:0] held_min_r, held_min_nxt;
  logic                                   min_vld_r, min_vld_nxt;
  logic signed [ppd_pkg::SAMPLE_BITS-1:0] held_max_r, held_max_nxt;
  logic                                   max_vld_r, max_vld_nxt;
  logic [ppd_pkg::INDEX_BITS-1:0]         min_pos_r, min_pos_nxt;
  logic [ppd_pkg::INDEX_BITS-1:0]         max_pos_r, max_pos_nxt;
  logic [ppd_pkg::INDEX_BITS-1:0]         prior_pos_r, prior_pos_nxt;
  logic [ppd_pkg::COUNT_BITS-1:0]         periods_r, periods_nxt;

  logic                                   adv;
  logic                                   emit;
  ppd_pkg::out_item_t                     rec;
  logic signed [ppd_pkg::SAMPLE_BITS-1:0] cur;
  logic [ppd_pkg::INDEX_BITS-1:0]         mid_index;
  logic [PROD_BITS-1:0]                   lhs;
  logic [PROD_BITS-1:0]                   rhs;

  // Handshakes
  assign adv       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || adv;
  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;
  assign pready    = 1'b1;

  // Register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r    <= ppd_pkg::RATIO_RESET;
      min_peak_r <= ppd_pkg::MIN_PEAK_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (ppd_pkg::cfg_reg_t'(paddr[2]))
        ppd_pkg::REG_RATIO_Q4: ratio_r    <= pwdata[ppd_pkg::RATIO_BITS-1:0];
        ppd_pkg::REG_MIN_PEAK: min_peak_r <= signed'(pwdata[ppd_pkg::SAMPLE_BITS-1:0]);
        default: ;
      endcase
    end
  end

  // Register read
  always_comb begin
    case (ppd_pkg::cfg_reg_t'(paddr[2]))
      ppd_pkg::REG_RATIO_Q4: prdata = ppd_pkg::DATA_BITS'(ratio_r);
      ppd_pkg::REG_MIN_PEAK: prdata = ppd_pkg::DATA_BITS'(unsigned'(min_peak_r));
      default:               prdata = '0;
    endcase
  end

  // Input register: hold one transaction until the update stage takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
  end

  // Update pass: extremum tests, ratio check, record build
  always_comb begin
    older_nxt     = older_r;
    newer_nxt     = newer_r;
    primed_nxt    = primed_r;
    count_nxt     = count_r;
    held_min_nxt  = held_min_r;
    min_vld_nxt   = min_vld_r;
    held_max_nxt  = held_max_r;
    max_vld_nxt   = max_vld_r;
    min_pos_nxt   = min_pos_r;
    max_pos_nxt   = max_pos_r;
    prior_pos_nxt = prior_pos_r;
    periods_nxt   = periods_r;
    emit          = 1'b0;
    cur           = in_item_r.sample;
    mid_index     = (count_r != '0) ? count_r - 1'b1 : '0;
    lhs           = '0;
    rhs           = '0;

    rec.peak_index    = ppd_pkg::sat_out(max_pos_r);
    rec.peak_value    = held_max_r;
    rec.min_gap       = '0;
    rec.gap_valid     = 1'b0;
    rec.period_number = periods_r;
    rec.is_final      = 1'b0;

    if (in_item_r.func == ppd_pkg::FUNC_FLUSH) begin
      // Flush a held peak as the final record, then drop all state
      emit          = max_vld_r && (held_max_r > min_peak_r);
      rec.is_final  = 1'b1;
      older_nxt     = '0;
      newer_nxt     = '0;
      primed_nxt    = '0;
      count_nxt     = '0;
      held_min_nxt  = '0;
      min_vld_nxt   = 1'b0;
      held_max_nxt  = '0;
      max_vld_nxt   = 1'b0;
      min_pos_nxt   = '0;
      max_pos_nxt   = '0;
      prior_pos_nxt = '0;
      periods_nxt   = '0;
    end else begin
      if (count_r != ppd_pkg::INDEX_MAX) begin
        count_nxt = count_r + 1'b1;
      end
      older_nxt = newer_r;
      newer_nxt = cur;

      if (primed_r != PRIMED_FULL) begin
        // Still filling the sample window
        primed_nxt = primed_r + 1'b1;
      end else begin
        // Local minimum below the held one
        if (older_r >= newer_r && newer_r <= cur &&
            (!min_vld_r || newer_r < held_min_r)) begin
          held_min_nxt = newer_r;
          min_vld_nxt  = 1'b1;
          min_pos_nxt  = mid_index;
        end
        // Local maximum above the held one and the floor; drops the minimum
        if (older_r <= newer_r && newer_r >= cur &&
            (!max_vld_r || newer_r > held_max_r) && newer_r > min_peak_r) begin
          held_max_nxt = newer_r;
          max_vld_nxt  = 1'b1;
          min_vld_nxt  = 1'b0;
          max_pos_nxt  = mid_index;
        end

        // Ratio test: |max| * 16 >= ratio * |min|
        lhs = PROD_BITS'(mag(held_max_nxt)) << 4;
        rhs = ratio_r * mag(held_min_nxt);

        if (max_vld_nxt && min_vld_nxt && held_max_nxt != '0 && held_min_nxt != '0 &&
            lhs >= rhs) begin
          emit              = 1'b1;
          rec.peak_index    = ppd_pkg::sat_out(max_pos_nxt);
          rec.peak_value    = held_max_nxt;
          rec.gap_valid     = (periods_r != '0);
          rec.min_gap       = (periods_r != '0) ?
                              ppd_pkg::sat_out(min_pos_nxt - prior_pos_r) : '0;
          prior_pos_nxt     = min_pos_nxt;
          if (periods_r != ppd_pkg::COUNT_MAX) begin
            periods_nxt = periods_r + 1'b1;
          end
          min_vld_nxt = 1'b0;
          max_vld_nxt = 1'b0;
        end
      end
    end
  end

  // Advance detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r     <= '0;
      newer_r     <= '0;
      primed_r    <= '0;
      count_r     <= '0;
      held_min_r  <= '0;
      min_vld_r   <= 1'b0;
      held_max_r  <= '0;
      max_vld_r   <= 1'b0;
      min_pos_r   <= '0;
      max_pos_r   <= '0;
      prior_pos_r <= '0;
      periods_r   <= '0;
    end else if (adv) begin
      older_r     <= older_nxt;
      newer_r     <= newer_nxt;
      primed_r    <= primed_nxt;
      count_r     <= count_nxt;
      held_min_r  <= held_min_nxt;
      min_vld_r   <= min_vld_nxt;
      held_max_r  <= held_max_nxt;
      max_vld_r   <= max_vld_nxt;
      min_pos_r   <= min_pos_nxt;
      max_pos_r   <= max_pos_nxt;
      prior_pos_r <= prior_pos_nxt;
      periods_r   <= periods_nxt;
    end
  end

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= emit;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_item_r <= rec;
    end
  end

endmodule

FILE: sv/ppd_checker.sv
// Port-level checks for the period peak detector, bound to its top level.
// Depends on ppd_pkg and period_peak_detector_unit.
module ppd_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input ppd_pkg::in_item_t    in_item,
  input logic                 out_valid,
  input logic                 out_ready,
  input ppd_pkg::out_item_t   out_item
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed or dropped while stalled");

  // With no result pending the input side never stalls
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

  // Period records carry a gap from the second period on
  a_gap_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.is_final |-> out_item.gap_valid == (out_item.period_number != '0))
    else $error("gap_valid disagrees with period_number");

  // Final and first records carry no gap
  a_gap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.is_final || !out_item.gap_valid) |->
      !out_item.gap_valid && out_item.min_gap == '0)
    else $error("gap set on a record without a valid gap");

endmodule

bind period_peak_detector_unit ppd_checker u_ppd_checker (.*);

FILE: tb/tb_period_peak_detector_unit.sv
// Self-checking testbench for period_peak_detector_unit: a directed opening, then
// shaped random sample streams under several register settings, with back-pressure.
// Depends on ppd_pkg and the detector top level only.
module tb_period_peak_detector_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RESET_CYCLES  = 12;
  localparam int          SETTLE_CYCLES = 8;
  localparam int unsigned LIMIT_CYCLES  = 200000;
  localparam int          PHASE_ITEMS   = 130;
  localparam int          FLUSH_MARK    = 100000;
  localparam int          LONG_HOLD     = 300;
  localparam int          REPORT_LIMIT  = 10;

  // Register settings of the fixed phases; two random phases follow them
  localparam int FIXED_PHASES = 6;
  localparam int PHASE_RATIO[FIXED_PHASES] = '{112, 0, 255, 255, 16, 112};
  localparam int PHASE_FLOOR[FIXED_PHASES] = '{0, -32768, 32767, -32768, 1000, 0};

  // Receiver stall patterns
  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PULSE} sink_mode_t;

  // Tracks the detector's state and holds the period records still owed
  class period_record_checker;
    logic [ppd_pkg::RATIO_BITS-1:0]         ratio;
    logic signed [ppd_pkg::SAMPLE_BITS-1:0] peak_floor;
    logic signed [ppd_pkg::SAMPLE_BITS-1:0] prev2, prev1;
    int unsigned                            fill;
    logic [ppd_pkg::INDEX_BITS-1:0]         next_index;
    logic signed [ppd_pkg::SAMPLE_BITS-1:0] trough, crest;
    bit                                     trough_held, crest_held;
    logic [ppd_pkg::INDEX_BITS-1:0]         trough_at, crest_at, last_trough_at;
    logic [ppd_pkg::COUNT_BITS-1:0]         period_count;
    ppd_pkg::out_item_t                     owed_records[$];
    int unsigned                            mismatches;
    int unsigned                            records_checked;

    function new();
      ratio           = ppd_pkg::RATIO_RESET;
      peak_floor      = ppd_pkg::MIN_PEAK_RESET;
      mismatches      = 0;
      records_checked = 0;
      clear_stream();
    endfunction

    // Drop all stream state; registers are kept
    function void clear_stream();
      prev2          = '0;
      prev1          = '0;
      fill           = 0;
      next_index     = '0;
      trough         = '0;
      crest          = '0;
      trough_held    = 1'b0;
      crest_held     = 1'b0;
      trough_at      = '0;
      crest_at       = '0;
      last_trough_at = '0;
      period_count   = '0;
    endfunction

    function void set_register(ppd_pkg::cfg_reg_t which,
                               logic [ppd_pkg::DATA_BITS-1:0] value);
      case (which)
        ppd_pkg::REG_RATIO_Q4: ratio = value[ppd_pkg::RATIO_BITS-1:0];
        ppd_pkg::REG_MIN_PEAK: peak_floor = value[ppd_pkg::SAMPLE_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void owe_record(logic [ppd_pkg::INDEX_BITS-1:0] gap, bit gap_ok, bit closing);
      ppd_pkg::out_item_t rec;
      rec.peak_index    = ppd_pkg::OUT_BITS'(crest_at);
      rec.peak_value    = crest;
      rec.min_gap       = ppd_pkg::OUT_BITS'(gap);
      rec.gap_valid     = gap_ok;
      rec.period_number = period_count;
      rec.is_final      = closing;
      owed_records.push_back(rec);
    endfunction

    // Advance the prediction by one accepted input transaction
    function void note_transaction(ppd_pkg::in_item_t item);
      logic signed [ppd_pkg::SAMPLE_BITS-1:0] cur;
      logic [ppd_pkg::INDEX_BITS-1:0]         cur_at, mid_at;
      longint unsigned                        crest_mag, trough_mag;
      bit                                     gap_ok;

      // End of stream: flush a held peak still above the floor, then start afresh
      if (item.func == ppd_pkg::FUNC_FLUSH) begin
        if (crest_held && crest > peak_floor) begin
          owe_record('0, 1'b0, 1'b1);
        end
        clear_stream();
        return;
      end

      cur    = item.sample;
      cur_at = next_index;
      if (next_index != ppd_pkg::INDEX_MAX) begin
        next_index++;
      end

      // The first two samples only prime the window
      if (fill < 2) begin
        prev2 = prev1;
        prev1 = cur;
        fill++;
        return;
      end

      mid_at = (cur_at != 0) ? cur_at - 1'b1 : '0;

      // Test the middle sample as a minimum, then as a maximum
      if (prev2 >= prev1 && prev1 <= cur && (!trough_held || prev1 < trough)) begin
        trough      = prev1;
        trough_held = 1'b1;
        trough_at   = mid_at;
      end
      if (prev2 <= prev1 && prev1 >= cur && (!crest_held || prev1 > crest) &&
          prev1 > peak_floor) begin
        crest       = prev1;
        crest_held  = 1'b1;
        trough_held = 1'b0;
        crest_at    = mid_at;
      end

      prev2 = prev1;
      prev1 = cur;

      crest_mag  = (crest < 0) ? -longint'(crest) : longint'(crest);
      trough_mag = (trough < 0) ? -longint'(trough) : longint'(trough);
      if (crest_held && trough_held && crest != 0 && trough != 0 &&
          crest_mag * 16 >= longint'(ratio) * trough_mag) begin
        gap_ok = (period_count != 0);
        owe_record(gap_ok ? trough_at - last_trough_at : '0, gap_ok, 1'b0);
        last_trough_at = trough_at;
        if (period_count != ppd_pkg::COUNT_MAX) begin
          period_count++;
        end
        trough_held = 1'b0;
        crest_held  = 1'b0;
      end
    endfunction

    function void complain(ppd_pkg::out_item_t want, ppd_pkg::out_item_t got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("record %0d mismatch: expected index %0d value %0d gap %0d/%0b period %0d final %0b",
                 records_checked, want.peak_index, want.peak_value, want.min_gap,
                 want.gap_valid, want.period_number, want.is_final);
        $display("  got index %0d value %0d gap %0d/%0b period %0d final %0b",
                 got.peak_index, got.peak_value, got.min_gap, got.gap_valid,
                 got.period_number, got.is_final);
      end
    endfunction

    // Compare a result transaction with the oldest owed record
    function void check_record(ppd_pkg::out_item_t got);
      ppd_pkg::out_item_t want;
      records_checked++;
      if (owed_records.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("record %0d arrived with nothing expected: index %0d value %0d",
                   records_checked, got.peak_index, got.peak_value);
        end
        return;
      end
      want = owed_records.pop_front();
      if (got.peak_index !== want.peak_index || got.peak_value !== want.peak_value ||
          got.min_gap !== want.min_gap || got.gap_valid !== want.gap_valid ||
          got.period_number !== want.period_number || got.is_final !== want.is_final) begin
        complain(want, got);
      end
    endfunction
  endclass

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  ppd_pkg::in_item_t              in_item   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  ppd_pkg::out_item_t             out_item;
  logic                           psel      = 1'b0;
  logic                           penable   = 1'b0;
  logic                           pwrite    = 1'b0;
  logic [ppd_pkg::ADDR_BITS-1:0]  paddr     = '0;
  logic [ppd_pkg::DATA_BITS-1:0]  pwdata    = '0;
  logic [ppd_pkg::DATA_BITS-1:0]  prdata;
  logic                           pready;

  period_record_checker board = new();

  int burst_left = 0;
  int wave_level = 0;
  bit wave_up    = 1'b0;

  // Opening stream under reset settings: priming, extremes, zero minimum, flushes
  int opening_run[$] = '{5, 3, 1, 2, 32767, 100, -1, 0, 0, 0, -32768, -32768, 10, 5, 3,
                         FLUSH_MARK, FLUSH_MARK, -32768, 32767, FLUSH_MARK};
  // Flat run where minimum and maximum fall on one sample
  int flat_run[$] = '{7, 7, 7, 7, -3, 9, FLUSH_MARK};

  period_peak_detector_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Note every accepted transaction on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        board.note_transaction(in_item);
      end
      if (out_valid && out_ready) begin
        board.check_record(out_item);
      end
    end
  end

  function automatic ppd_pkg::in_item_t sample_item(
      logic signed [ppd_pkg::SAMPLE_BITS-1:0] value);
    ppd_pkg::in_item_t item;
    item.func   = ppd_pkg::FUNC_SAMPLE;
    item.sample = value;
    return item;
  endfunction

  function automatic ppd_pkg::in_item_t flush_item();
    ppd_pkg::in_item_t item;
    item.func   = ppd_pkg::FUNC_FLUSH;
    item.sample = ppd_pkg::SAMPLE_BITS'($urandom);
    return item;
  endfunction

  // Offer one transaction in bursts with random gaps; hold it until accepted
  task automatic send_item(ppd_pkg::in_item_t item);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  // Stop offering, wait for every owed record, then let the pipeline empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.owed_records.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(ppd_pkg::cfg_reg_t which,
                                logic [ppd_pkg::DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_register(which, value);
  endtask

  task automatic reconfigure(logic [ppd_pkg::RATIO_BITS-1:0] ratio,
                             logic signed [ppd_pkg::SAMPLE_BITS-1:0] floor_level);
    wait_idle();
    write_register(ppd_pkg::REG_RATIO_Q4, ppd_pkg::DATA_BITS'(ratio));
    write_register(ppd_pkg::REG_MIN_PEAK, ppd_pkg::DATA_BITS'(floor_level));
  endtask

  task automatic play_pattern(input int pattern[$]);
    foreach (pattern[i]) begin
      if (pattern[i] == FLUSH_MARK) begin
        send_item(flush_item());
      end else begin
        send_item(sample_item(pattern[i][ppd_pkg::SAMPLE_BITS-1:0]));
      end
    end
  endtask

  // Mostly triangle waves with small troughs and tall crests, some noise and flushes
  task automatic play_waveform(int count);
    int sent;
    int roll;
    int target;
    int start;
    int steps;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        send_item(flush_item());
        sent++;
      end else if (roll < 14) begin
        send_item(sample_item(ppd_pkg::SAMPLE_BITS'($urandom)));
        sent++;
      end else begin
        roll = $urandom_range(0, 9);
        if (wave_up) begin
          target = (roll < 8) ? $urandom_range(64, 32767) :
                   (roll == 8) ? 32767 : -$urandom_range(0, 2000);
        end else begin
          target = (roll < 6) ? $urandom_range(0, 40) - 20 :
                   (roll < 8) ? $urandom_range(0, 400) - 200 :
                   (roll == 8) ? -32768 : 0;
        end
        start = wave_level;
        steps = $urandom_range(1, 5);
        for (int s = 1; s <= steps && sent < count; s++) begin
          wave_level = start + (target - start) * s / steps;
          send_item(sample_item(wave_level[ppd_pkg::SAMPLE_BITS-1:0]));
          sent++;
        end
        // Repeat the vertex now and then to make a flat run
        if ($urandom_range(0, 4) == 0 && sent < count) begin
          send_item(sample_item(wave_level[ppd_pkg::SAMPLE_BITS-1:0]));
          sent++;
        end
        wave_up = !wave_up;
      end
    end
  endtask

  // Receiver: changing stall patterns, plus two long hold-offs to back up the block
  initial begin : result_sink
    sink_mode_t mode;
    int         span;
    int         hold_left;
    int         holds_done;
    mode       = SINK_OPEN;
    span       = 0;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_done < 2 &&
          board.records_checked >= ((holds_done == 0) ? 10 : 60)) begin
        hold_left = LONG_HOLD;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = sink_mode_t'($urandom_range(0, 3));
          span = $urandom_range(8, 80);
        end
        span--;
        case (mode)
          SINK_OPEN:   out_ready <= 1'b1;
          SINK_COIN:   out_ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:     out_ready <= span[2];
        endcase
      end
    end
  end

  // Give up on a hung run
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("period_peak_detector_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    play_pattern(opening_run);
    reconfigure(8'd0, -16'sd32768);
    play_pattern(flat_run);

    // Random phases: fixed settings including the extremes, then random ones
    for (int p = 0; p < FIXED_PHASES + 2; p++) begin
      if (p < FIXED_PHASES) begin
        reconfigure(ppd_pkg::RATIO_BITS'(PHASE_RATIO[p]),
                    ppd_pkg::SAMPLE_BITS'(PHASE_FLOOR[p]));
      end else begin
        reconfigure(ppd_pkg::RATIO_BITS'($urandom), ppd_pkg::SAMPLE_BITS'($urandom));
      end
      play_waveform(PHASE_ITEMS);
    end

    wait_idle();
    if (board.mismatches == 0) begin
      $display("period_peak_detector_unit regression: pass");
    end else begin
      $display("period_peak_detector_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/ppd_pkg.sv
sv/period_peak_detector_unit.sv
sv/ppd_checker.sv
tb/tb_period_peak_detector_unit.sv
